/* rtl/core/i2p_pkg.sv */
// ----------------------------------------------------------------------------
// i2p_pkg
// Operator codes, precedence, characters and stack commands shared by the
// infix to postfix converter and its operator stack.
// ----------------------------------------------------------------------------
package i2p_pkg;

    typedef logic [2:0] op_code_t;
    typedef logic [1:0] status_t;

    localparam op_code_t OP_LPAREN = 3'd0;
    localparam op_code_t OP_PLUS   = 3'd1;
    localparam op_code_t OP_MINUS  = 3'd2;
    localparam op_code_t OP_MUL    = 3'd3;
    localparam op_code_t OP_DIV    = 3'd4;
    localparam op_code_t OP_MOD    = 3'd5;
    localparam op_code_t OP_POW    = 3'd6;

    localparam logic [7:0] CH_LPAREN = 8'h28;
    localparam logic [7:0] CH_RPAREN = 8'h29;
    localparam logic [7:0] CH_PLUS   = 8'h2B;
    localparam logic [7:0] CH_MINUS  = 8'h2D;
    localparam logic [7:0] CH_MUL    = 8'h2A;
    localparam logic [7:0] CH_DIV    = 8'h2F;
    localparam logic [7:0] CH_MOD    = 8'h25;
    localparam logic [7:0] CH_POW    = 8'h5E;

    localparam status_t STAT_OK         = 2'd0;
    localparam status_t STAT_OVERFLOW   = 2'd1;
    localparam status_t STAT_OPEN_CLOSE = 2'd2;
    localparam status_t STAT_OPEN_LEFT  = 2'd3;

    typedef struct packed {
        logic     push;
        logic     pop;
        logic     clear;
        op_code_t code;
    } stack_cmd_t;

    typedef struct packed {
        logic     valid;
        op_code_t code;
    } op_dec_t;

    function automatic logic [2:0] op_level(input op_code_t code);
        logic [2:0] lvl;
        case (code)
            OP_LPAREN:                lvl = 3'd1;
            OP_PLUS, OP_MINUS:        lvl = 3'd2;
            OP_MUL, OP_DIV, OP_MOD:   lvl = 3'd3;
            OP_POW:                   lvl = 3'd4;
            default:                  lvl = 3'd0;
        endcase
        return lvl;
    endfunction

    function automatic logic [7:0] op_char(input op_code_t code);
        logic [7:0] ch;
        case (code)
            OP_LPAREN: ch = CH_LPAREN;
            OP_PLUS:   ch = CH_PLUS;
            OP_MINUS:  ch = CH_MINUS;
            OP_MUL:    ch = CH_MUL;
            OP_DIV:    ch = CH_DIV;
            OP_MOD:    ch = CH_MOD;
            OP_POW:    ch = CH_POW;
            default:   ch = 8'h00;
        endcase
        return ch;
    endfunction

    function automatic op_dec_t op_decode(input logic [7:0] ch);
        op_dec_t d;
        d.valid = 1'b1;
        unique case (ch)
            CH_LPAREN: d.code = OP_LPAREN;
            CH_PLUS:   d.code = OP_PLUS;
            CH_MINUS:  d.code = OP_MINUS;
            CH_MUL:    d.code = OP_MUL;
            CH_DIV:    d.code = OP_DIV;
            CH_MOD:    d.code = OP_MOD;
            CH_POW:    d.code = OP_POW;
            default: begin
                d.valid = 1'b0;
                d.code  = OP_LPAREN;
            end
        endcase
        return d;
    endfunction

endpackage

/* rtl/core/infix_to_postfix_converter.sv */
// Timing: a plain character appears on the output in the cycle after it is taken; an
// operator or ')' holds the input while it pops each operator that must leave; end of
// expression pops every held stack entry, then sees the stack empty and emits the status
// item. Output stalls hold the pop loop and the output register.
// Throughput: one item per cycle for plain characters while the output is not stalled,
// otherwise set by the pop loop that retires one stack entry per cycle through the stack RAM read port.
// Reset clears the stack count, error state and output valid; the RAM is not cleared.
// ----------------------------------------------------------------------------
// infix_to_postfix_converter
// Shunting-yard converter: infix characters in, postfix characters out, with
// a status item closing each expression.
// ----------------------------------------------------------------------------
module infix_to_postfix_converter #(
    parameter int STACK_DEPTH = 32
) (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [7:0] s_tdata,   // [7:0] symbol
    input  logic       s_tlast,   // expr_last
    output logic       m_tvalid,
    input  logic       m_tready,
    output logic [7:0] m_tdata,   // [7:0] out_symbol
    output logic       m_tlast,   // run_last
    output logic [2:0] m_tuser    // [0] expr_end, [2:1] status
);

    localparam int AW = $clog2(STACK_DEPTH);

    typedef enum logic [4:0] {
        S_IDLE   = 5'b00001,
        S_OPER   = 5'b00010,
        S_CLOSE  = 5'b00100,
        S_FLUSH  = 5'b01000,
        S_STATUS = 5'b10000
    } state_t;

    state_t               state_reg, state_next;
    i2p_pkg::op_code_t    code_reg, code_next;
    logic                 last_reg, last_next;
    i2p_pkg::status_t     err_reg, err_next;
    logic                 open_reg, open_next;

    logic                 m_valid_reg;
    logic [7:0]           m_data_reg;
    logic                 m_last_reg;
    logic [2:0]           m_user_reg;

    i2p_pkg::stack_cmd_t  cmd;
    i2p_pkg::op_code_t    stk_top, stk_second;
    logic [AW-1:0]        stk_count;

    i2p_pkg::op_dec_t     dec;
    logic                 out_free;
    logic                 push_req;
    i2p_pkg::op_code_t    push_code;
    logic                 full;
    logic                 emit;
    logic [7:0]           e_sym;
    logic                 e_last;
    logic                 e_end;
    i2p_pkg::status_t     e_status;
    logic [2:0]           lvl;
    state_t               done_state;

    i2p_stack #(
        .STACK_DEPTH (STACK_DEPTH),
        .AW          (AW)
    ) u_stack (
        .aclk    (aclk),
        .aresetn (aresetn),
        .cmd     (cmd),
        .top     (stk_top),
        .second  (stk_second),
        .count   (stk_count)
    );

    assign out_free   = !m_valid_reg || m_tready;
    assign s_tready   = (state_reg == S_IDLE) && out_free;
    assign dec        = i2p_pkg::op_decode(s_tdata);
    assign full       = stk_count >= AW'(STACK_DEPTH - 1);
    assign lvl        = i2p_pkg::op_level(code_reg);
    assign done_state = last_reg ? S_FLUSH : S_IDLE;

    always_comb begin
        state_next = state_reg;
        code_next  = code_reg;
        last_next  = last_reg;
        err_next   = err_reg;
        open_next  = open_reg;
        cmd        = '0;
        push_req   = 1'b0;
        push_code  = i2p_pkg::OP_LPAREN;
        emit       = 1'b0;
        e_sym      = 8'h00;
        e_last     = 1'b0;
        e_end      = 1'b0;
        e_status   = i2p_pkg::STAT_OK;

        unique case (state_reg)
            S_IDLE: begin
                if (s_tvalid && out_free) begin
                    last_next = s_tlast;
                    if (s_tdata == i2p_pkg::CH_RPAREN) begin
                        state_next = S_CLOSE;
                    end else if (dec.valid && dec.code == i2p_pkg::OP_LPAREN) begin
                        push_req   = 1'b1;
                        push_code  = i2p_pkg::OP_LPAREN;
                        state_next = s_tlast ? S_FLUSH : S_IDLE;
                    end else if (dec.valid) begin
                        code_next  = dec.code;
                        state_next = S_OPER;
                    end else begin
                        emit       = 1'b1;
                        e_sym      = s_tdata;
                        e_last     = !s_tlast;
                        state_next = s_tlast ? S_FLUSH : S_IDLE;
                    end
                end
            end
            S_OPER: begin
                if (stk_count != '0 && i2p_pkg::op_level(stk_top) >= lvl) begin
                    if (out_free) begin
                        emit    = 1'b1;
                        e_sym   = i2p_pkg::op_char(stk_top);
                        // no further pop when the entry below ranks lower
                        e_last  = !last_reg && !(stk_count > AW'(1)
                                  && i2p_pkg::op_level(stk_second) >= lvl);
                        cmd.pop = 1'b1;
                    end
                end else begin
                    push_req   = 1'b1;
                    push_code  = code_reg;
                    state_next = done_state;
                end
            end
            S_CLOSE: begin
                if (stk_count == '0) begin
                    if (err_reg == i2p_pkg::STAT_OK) begin
                        err_next = i2p_pkg::STAT_OPEN_CLOSE;
                    end
                    state_next = done_state;
                end else if (stk_top == i2p_pkg::OP_LPAREN) begin
                    cmd.pop    = 1'b1;
                    state_next = done_state;
                end else if (out_free) begin
                    emit    = 1'b1;
                    e_sym   = i2p_pkg::op_char(stk_top);
                    e_last  = !last_reg && (stk_count == AW'(1)
                              || stk_second == i2p_pkg::OP_LPAREN);
                    cmd.pop = 1'b1;
                end
            end
            S_FLUSH: begin
                if (stk_count == '0) begin
                    state_next = S_STATUS;
                end else if (stk_top == i2p_pkg::OP_LPAREN) begin
                    cmd.pop   = 1'b1;
                    open_next = 1'b1;
                end else if (out_free) begin
                    emit    = 1'b1;
                    e_sym   = i2p_pkg::op_char(stk_top);
                    cmd.pop = 1'b1;
                end
            end
            S_STATUS: begin
                if (out_free) begin
                    emit      = 1'b1;
                    e_last    = 1'b1;
                    e_end     = 1'b1;
                    if (err_reg != i2p_pkg::STAT_OK) begin
                        e_status = err_reg;
                    end else if (open_reg) begin
                        e_status = i2p_pkg::STAT_OPEN_LEFT;
                    end
                    cmd.clear  = 1'b1;
                    err_next   = i2p_pkg::STAT_OK;
                    open_next  = 1'b0;
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase

        // push onto a full stack is dropped and flagged
        if (push_req) begin
            if (full) begin
                if (err_reg == i2p_pkg::STAT_OK) begin
                    err_next = i2p_pkg::STAT_OVERFLOW;
                end
            end else begin
                cmd.push = 1'b1;
                cmd.code = push_code;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            err_reg     <= i2p_pkg::STAT_OK;
            open_reg    <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            err_reg   <= err_next;
            open_reg  <= open_next;
            if (emit) begin
                m_valid_reg <= 1'b1;
            end else if (m_tready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        code_reg <= code_next;
        last_reg <= last_next;
        if (emit) begin
            m_data_reg <= e_sym;
            m_last_reg <= e_last;
            m_user_reg <= {e_status, e_end};
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;
    assign m_tlast  = m_last_reg;
    assign m_tuser  = m_user_reg;

endmodule

/* rtl/core/i2p_stack.sv */
// ----------------------------------------------------------------------------
// i2p_stack
// Operator stack: top entry in a register, the rest in a synchronous RAM
// whose registered read port always holds the entry just below the top.
// ----------------------------------------------------------------------------
module i2p_stack #(
    parameter int STACK_DEPTH = 32,
    parameter int AW          = 5
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  i2p_pkg::stack_cmd_t   cmd,
    output i2p_pkg::op_code_t     top,
    output i2p_pkg::op_code_t     second,
    output logic [AW-1:0]         count
);

    i2p_pkg::op_code_t mem [STACK_DEPTH];

    logic [AW-1:0]     count_reg, count_next;
    i2p_pkg::op_code_t top_reg, top_next;
    i2p_pkg::op_code_t rd_data_reg;
    logic              wr_en;
    logic [AW-1:0]     wr_addr;
    logic [AW-1:0]     rd_addr;

    always_comb begin
        count_next = count_reg;
        top_next   = top_reg;
        if (cmd.clear) begin
            count_next = '0;
        end else if (cmd.push) begin
            count_next = count_reg + AW'(1);
            top_next   = cmd.code;
        end else if (cmd.pop) begin
            count_next = count_reg - AW'(1);
            top_next   = rd_data_reg;
        end
    end

    // old top spills into RAM on push; read port tracks the entry below top
    assign wr_en   = cmd.push && !cmd.clear && (count_reg != '0);
    assign wr_addr = count_reg - AW'(1);
    assign rd_addr = count_next - AW'(2);

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= top_reg;
        end
        if (wr_en && (wr_addr == rd_addr)) begin
            rd_data_reg <= top_reg;
        end else begin
            rd_data_reg <= mem[rd_addr];
        end
        top_reg <= top_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= '0;
        end else begin
            count_reg <= count_next;
        end
    end

    assign top    = top_reg;
    assign second = rd_data_reg;
    assign count  = count_reg;

endmodule
